// ===== rtl/core/rfhex_pkg.sv =====
package rfhex_pkg;

  // Largest frame the decoder is built for, and the decode window width
  // (two extra characters of lookahead for the 0x prefix test).
  localparam int MAX_FRAME = 16;
  localparam int WIN_CHARS = MAX_FRAME + 2;

  typedef logic [MAX_FRAME-1:0][7:0] frame_t;
  typedef logic [WIN_CHARS-1:0][7:0] win_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SUM = 2'd1,
    ST_LEN = 2'd2
  } frame_status_t;

  typedef enum logic [1:0] {
    PH_WS,
    PH_PFX,
    PH_DIG,
    PH_END
  } hex_phase_t;

  // Event raised by the frame store for an accepted tail byte.
  typedef struct packed {
    logic valid;
    logic len_err;
  } frame_ev_t;

  // Decoded result handed to the output register.
  typedef struct packed {
    logic          valid;
    logic [31:0]   tag;
    frame_status_t status;
  } frame_res_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;

  function automatic logic hex_ok(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - CH_ZERO;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

  // Cut one field out of the frame; characters past the field or the
  // frame read as zero, which ends the field.
  function automatic win_t make_win(input frame_t f, input int start, input int len);
    win_t w;
    w = '0;
    for (int k = 0; k < WIN_CHARS; k++) begin
      if ((k < len) && (start + k < MAX_FRAME)) begin
        w[k] = f[start + k];
      end
    end
    return w;
  endfunction

  // Base-16 parse of one field: blanks, one sign, optional 0x, digits.
  function automatic logic [63:0] parse_hex(input win_t w);
    hex_phase_t  ph;
    logic        neg;
    logic        skip;
    logic        pfx;
    logic        dig;
    logic [63:0] v;
    logic [7:0]  c;
    ph   = PH_WS;
    neg  = 1'b0;
    skip = 1'b0;
    v    = '0;
    for (int i = 0; i < MAX_FRAME; i++) begin
      c   = w[i];
      pfx = 1'b0;
      dig = 1'b0;
      if (skip) begin
        skip = 1'b0;
      end else begin
        if (ph == PH_WS) begin
          if (is_space(c)) begin
            pfx = 1'b0;
          end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            neg = (c == CH_MINUS);
            ph  = PH_PFX;
          end else begin
            pfx = 1'b1;
          end
        end else if (ph == PH_PFX) begin
          pfx = 1'b1;
        end else if (ph == PH_DIG) begin
          dig = 1'b1;
        end
        if (pfx) begin
          ph = PH_DIG;
          if ((c == CH_ZERO) && ((w[i+1] | CH_SPACE) == CH_X) && hex_ok(w[i+2])) begin
            skip = 1'b1;
          end else begin
            dig = 1'b1;
          end
        end
        if (dig) begin
          if (hex_ok(c)) begin
            v = {v[59:0], hex_val(c)};
          end else begin
            ph = PH_END;
          end
        end
      end
    end
    return neg ? (64'd0 - v) : v;
  endfunction

endpackage

// ===== rtl/core/rfhex_frame.sv =====
module rfhex_frame
  import rfhex_pkg::*;
#(
  parameter int FRAME_BYTES = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic [7:0] head_byte,
  input  logic [7:0] tail_byte,
  output frame_ev_t  ev,
  output frame_t     frame
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(FRAME_BYTES);

  logic [7:0]       store_r [FRAME_BYTES];
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic             is_head;
  logic             is_tail;
  logic             do_store;

  // Head test wins when head and tail share a value.
  assign is_head  = (rx_byte == head_byte);
  assign is_tail  = !is_head && (rx_byte == tail_byte);
  assign do_store = accept && !is_head && !is_tail && (fill_r < FULL);

  assign ev.valid   = accept && is_tail;
  assign ev.len_err = (fill_r != FULL);

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (is_head || (is_tail && (fill_r != FULL))) begin
        fill_nxt = '0;
      end else if (do_store) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_store) begin
      store_r[fill_r[IDX_W-1:0]] <= rx_byte;
    end
  end

  for (genvar k = 0; k < MAX_FRAME; k++) begin : g_frame
    if (k < FRAME_BYTES) begin : g_used
      assign frame[k] = store_r[k];
    end else begin : g_pad
      assign frame[k] = '0;
    end
  end

endmodule

// ===== rtl/core/rfhex_decode.sv =====
module rfhex_decode
  import rfhex_pkg::*;
#(
  parameter int FRAME_BYTES    = 12,
  parameter int TAG_DIGITS     = 8,
  parameter int VERSION_DIGITS = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  frame_ev_t  ev,
  input  frame_t     frame,
  output frame_res_t res
);

  localparam int DATA_LEN = VERSION_DIGITS + TAG_DIGITS;
  localparam int SUM_LEN  = (FRAME_BYTES > DATA_LEN) ? FRAME_BYTES - DATA_LEN : 0;
  localparam int N_PAIRS  = (DATA_LEN + 1) / 2;

  logic        valid_r;
  logic        len_err_r;
  logic [31:0] tag_r;
  logic [63:0] sum_r;
  logic [7:0]  calc_r;
  logic [63:0] tag_full;
  logic [63:0] sum_nxt;
  logic [7:0]  calc_nxt;
  logic [63:0] pair_full;
  logic        sum_match;

  // Parse tag, checksum and the data pairs from the store as it stands.
  always_comb begin
    tag_full = parse_hex(make_win(frame, VERSION_DIGITS, TAG_DIGITS));
    sum_nxt  = parse_hex(make_win(frame, DATA_LEN, SUM_LEN));
    calc_nxt = '0;
    pair_full = '0;
    for (int p = 0; p < N_PAIRS; p++) begin
      pair_full = parse_hex(make_win(frame, 2 * p, 2));
      calc_nxt  = calc_nxt ^ pair_full[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= ev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ev.valid) begin
      len_err_r <= ev.len_err;
      tag_r     <= tag_full[31:0];
      sum_r     <= sum_nxt;
      calc_r    <= calc_nxt;
    end
  end

  assign sum_match = (sum_r == {56'd0, calc_r});

  always_comb begin
    res.valid = valid_r;
    if (len_err_r) begin
      res.status = ST_LEN;
      res.tag    = '0;
    end else if (!sum_match) begin
      res.status = ST_SUM;
      res.tag    = '0;
    end else begin
      res.status = ST_OK;
      res.tag    = tag_r;
    end
  end

endmodule

// ===== rtl/core/rfid_ascii_hex_frame_decoder.sv =====
// Channel   Dir  Request content
// in_       in   in_tdata[7:0] = rx_byte
// out_      out  out_tdata[31:0] = tag_id, out_tuser[1:0] = frame_status
// cfg_      in   APB, 0x0 head_byte, 0x4 tail_byte (bit 2 selects)
//
// One byte is taken per cycle while in_tready is high. A tail byte's result
// passes two register stages: the parse register, then the output register.
// rst_n (synchronous) clears the fill count, the stage valids and the
// head/tail registers; the frame store holds no reset value.
// A stalled output holds the parse register only while it is full, so
// bytes that make no result keep flowing behind a waiting request.
module rfid_ascii_hex_frame_decoder
  import rfhex_pkg::*;
#(
  parameter int FRAME_BYTES    = 12,
  parameter int TAG_DIGITS     = 8,
  parameter int VERSION_DIGITS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] rx_byte
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [31:0] tag_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // out_tuser: [1:0] frame_status
  output logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [7:0] HEAD_RST = 8'h02;
  localparam logic [7:0] TAIL_RST = 8'h03;

  logic        out_valid_r;
  logic [31:0] out_tag_r;
  logic [1:0]  out_status_r;
  logic [7:0]  head_r;
  logic [7:0]  tail_r;
  logic        out_can;
  logic        load;
  logic        accept;
  logic        cfg_wr;
  frame_ev_t   ev;
  frame_t      frame;
  frame_res_t  res;

  // Register writes: setup, then access with pready tied high.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = {24'd0, cfg_paddr[2] ? tail_r : head_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= HEAD_RST;
      tail_r <= TAIL_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        tail_r <= cfg_pwdata[7:0];
      end else begin
        head_r <= cfg_pwdata[7:0];
      end
    end
  end

  // Advance the output register when it is empty or taken; advance the
  // parse register when it is empty or can move on.
  assign out_can   = !out_valid_r || out_tready;
  assign load      = !res.valid || out_can;
  assign in_tready = load;
  assign accept    = in_tvalid && load;

  rfhex_frame #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .rx_byte  (in_tdata),
    .head_byte(head_r),
    .tail_byte(tail_r),
    .ev       (ev),
    .frame    (frame)
  );

  rfhex_decode #(
    .FRAME_BYTES   (FRAME_BYTES),
    .TAG_DIGITS    (TAG_DIGITS),
    .VERSION_DIGITS(VERSION_DIGITS)
  ) u_decode (
    .clk  (clk),
    .rst_n(rst_n),
    .load (load),
    .ev   (ev),
    .frame(frame),
    .res  (res)
  );

  // Output register: hold the request until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_can) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_can && res.valid) begin
      out_tag_r    <= res.tag;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tag_r;
  assign out_tuser  = out_status_r;

endmodule
